[rtl/pciw_pkg.sv]
// Shared types and constants for the windowed prime counter.
`default_nettype none

package pciw_pkg;

    localparam int unsigned START_W      = 31;
    localparam int unsigned WINDOW_W     = 21;
    localparam int unsigned COUNT_W      = 21;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(100000);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CAND,
        ST_CHECK,
        ST_DIV,
        ST_REM,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_window;
        logic init_divisor;
        logic start_div;
        logic div_step;
        logic next_divisor;
        logic count_prime;
        logic next_cand;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic window_done;
        logic cand_small;
        logic square_over;
        logic div_last;
        logic rem_zero;
    } t_sts;

endpackage

`default_nettype wire

[rtl/pciw_dp.sv]
// Datapath: window register, candidate, divisor and restoring remainder unit.
`default_nettype none

module pciw_dp #(
    parameter int unsigned NUMBER_WIDTH = 32
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [pciw_pkg::WINDOW_W-1:0]    i_cfg_wdata,
    input  wire  [pciw_pkg::START_W-1:0]     i_start_value,
    input  pciw_pkg::t_cmd                   i_cmd,
    output pciw_pkg::t_sts                   o_sts,
    output logic [pciw_pkg::COUNT_W-1:0]     o_prime_count
);
    import pciw_pkg::*;

    localparam int unsigned BIT_W = (NUMBER_WIDTH > 1) ? $clog2(NUMBER_WIDTH) : 1;

    logic [WINDOW_W-1:0]     r_window;
    logic [WINDOW_W-1:0]     r_remain;
    logic [COUNT_W-1:0]      r_count;
    logic [NUMBER_WIDTH-1:0] r_cand;
    logic [NUMBER_WIDTH-1:0] r_divisor;
    logic [NUMBER_WIDTH:0]   r_square;
    logic [NUMBER_WIDTH-1:0] r_rem;
    logic [NUMBER_WIDTH-1:0] r_shift;
    logic [BIT_W-1:0]        r_bit;

    logic [NUMBER_WIDTH:0]   trial;
    logic [NUMBER_WIDTH:0]   divisor_ext;
    logic                    fits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_wdata;
        end
    end

    // One quotient bit per cycle: shift the next dividend bit into the remainder.
    always_comb begin
        trial       = {r_rem, r_shift[NUMBER_WIDTH-1]};
        divisor_ext = {1'b0, r_divisor};
        fits        = (trial >= divisor_ext);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_window) begin
            r_remain <= r_window;
            r_count  <= '0;
            r_cand   <= NUMBER_WIDTH'(i_start_value);
        end
        if (i_cmd.count_prime) begin
            r_count <= r_count + COUNT_W'(1);
        end
        if (i_cmd.next_cand) begin
            r_cand   <= r_cand + NUMBER_WIDTH'(1);
            r_remain <= r_remain - WINDOW_W'(1);
        end
        if (i_cmd.init_divisor) begin
            r_divisor <= NUMBER_WIDTH'(2);
            r_square  <= (NUMBER_WIDTH + 1)'(4);
        end
        if (i_cmd.next_divisor) begin
            // (d + 1)^2 = d^2 + 2d + 1
            r_divisor <= r_divisor + NUMBER_WIDTH'(1);
            r_square  <= r_square + {r_divisor, 1'b1};
        end
        if (i_cmd.start_div) begin
            r_rem   <= '0;
            r_shift <= r_cand;
            r_bit   <= BIT_W'(NUMBER_WIDTH - 1);
        end
        if (i_cmd.div_step) begin
            r_rem   <= fits ? NUMBER_WIDTH'(trial - divisor_ext) : trial[NUMBER_WIDTH-1:0];
            r_shift <= {r_shift[NUMBER_WIDTH-2:0], 1'b0};
            r_bit   <= r_bit - BIT_W'(1);
        end
    end

    always_comb begin
        o_sts.window_done = (r_remain == '0);
        o_sts.cand_small  = (r_cand < NUMBER_WIDTH'(2));
        o_sts.square_over = (r_square > {1'b0, r_cand});
        o_sts.div_last    = (r_bit == '0);
        o_sts.rem_zero    = (r_rem == '0);
    end

    assign o_prime_count = r_count;

endmodule

`default_nettype wire

[rtl/pciw_ctrl.sv]
// Controller: sequences candidates, divisors and remainder steps.
`default_nettype none

module pciw_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             start,
    output logic            busy,
    output logic            o_valid,
    input  pciw_pkg::t_sts  i_sts,
    output pciw_pkg::t_cmd  o_cmd
);
    import pciw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = (r_state != ST_IDLE);
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load_window = 1'b1;
                    n_state           = ST_CAND;
                end
            end
            ST_LOAD: begin
                n_state = ST_CAND;
            end
            ST_CAND: begin
                if (i_sts.window_done) begin
                    n_state = ST_DONE;
                end else if (i_sts.cand_small) begin
                    o_cmd.next_cand = 1'b1;
                end else begin
                    o_cmd.init_divisor = 1'b1;
                    n_state            = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // No divisor up to the square root divides the word: it is prime.
                if (i_sts.square_over) begin
                    o_cmd.count_prime = 1'b1;
                    o_cmd.next_cand   = 1'b1;
                    n_state           = ST_CAND;
                end else begin
                    o_cmd.start_div = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_REM;
                end
            end
            ST_REM: begin
                if (i_sts.rem_zero) begin
                    o_cmd.next_cand = 1'b1;
                    n_state         = ST_CAND;
                end else begin
                    o_cmd.next_divisor = 1'b1;
                    n_state            = ST_CHECK;
                end
            end
            ST_DONE: begin
                o_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/prime_count_in_window_core.sv]
// Each candidate in the window is tried against divisors from two upward, until one divides it
// or the divisor's square passes it; no divisors are tried on a candidate below two.
// The shared restoring remainder unit works one bit per cycle.
// One word at a time: the next word is taken in the cycle after the count is shown on o_valid.
// Reset (synchronous, active low) idles the controller and sets the window to 100000.
// The count is shown for one cycle only; the receiver cannot hold it off.
`default_nettype none

module prime_count_in_window_core #(
    parameter int unsigned NUMBER_WIDTH = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire  [pciw_pkg::WINDOW_W-1:0] i_cfg_wdata,
    input  wire                           start,
    output logic                          busy,
    input  wire  [pciw_pkg::START_W-1:0]  i_start_value,
    output logic                          o_valid,
    output logic [pciw_pkg::COUNT_W-1:0]  o_prime_count
);
    import pciw_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pciw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pciw_dp #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_start_value (i_start_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_prime_count (o_prime_count)
    );

endmodule

`default_nettype wire
